// File: hw/rtl/frlc_pkg.sv
package frlc_pkg;

    // Table geometry
    localparam int DEPTH       = 64;
    localparam int KEY_BITS    = 32;
    localparam int HANDLE_BITS = 16;
    localparam int SLOT_BITS   = $clog2(DEPTH);
    localparam int COUNT_BITS  = SLOT_BITS + 1;

    // Configuration port
    localparam int ADDR_BITS   = 3;
    localparam int DATA_BITS   = 32;
    localparam int LIMIT_BITS  = 7;
    localparam int REG_IDX_BITS = ADDR_BITS - 2;

    localparam logic [REG_IDX_BITS-1:0] REG_ENTRY_LIMIT = '0;
    localparam logic [LIMIT_BITS-1:0]   LIMIT_RESET     = LIMIT_BITS'(DEPTH);

    // Operation codes
    localparam logic FUNC_ADD    = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef struct packed {
        logic                   func;
        logic [KEY_BITS-1:0]    key;
        logic [HANDLE_BITS-1:0] handle;
    } frlc_req_t;

    typedef struct packed {
        logic                   hit;
        logic [HANDLE_BITS-1:0] found_handle;
        logic                   evicted;
        logic [KEY_BITS-1:0]    evicted_key;
    } frlc_rsp_t;

endpackage

// File: hw/rtl/frlc_cfg.sv
module frlc_cfg
    import frlc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [DATA_BITS-1:0]  pwdata,
    output logic [DATA_BITS-1:0]  prdata,
    output logic                  pready,
    output logic [LIMIT_BITS-1:0] entry_limit
);

    logic [LIMIT_BITS-1:0]   limit_reg;
    logic [REG_IDX_BITS-1:0] reg_idx;
    logic                    wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_BITS-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Write the limit register on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (wr_en && (reg_idx == REG_ENTRY_LIMIT))
        begin
            limit_reg <= pwdata[LIMIT_BITS-1:0];
        end
    end

    // Read back the register, zero elsewhere
    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_ENTRY_LIMIT)
        begin
            prdata = DATA_BITS'(limit_reg);
        end
    end

    assign entry_limit = limit_reg;

endmodule

// File: hw/rtl/frlc_store.sv
module frlc_store
    import frlc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  frlc_req_t             req,
    input  logic [LIMIT_BITS-1:0] entry_limit,
    output frlc_rsp_t             rsp
);

    logic [KEY_BITS-1:0]    key_reg    [DEPTH];
    logic [HANDLE_BITS-1:0] handle_reg [DEPTH];
    logic [DEPTH-1:0]       valid_reg;
    logic [DEPTH-1:0]       valid_next;
    logic [COUNT_BITS-1:0]  fill_reg;
    logic [SLOT_BITS-1:0]   oldest_reg;

    logic [DEPTH-1:0]       match;
    logic                   hit;
    logic [HANDLE_BITS-1:0] found;
    logic [LIMIT_BITS-1:0]  limit_eff;
    logic                   full;
    logic                   is_new_add;
    logic                   do_add;
    logic [SLOT_BITS-1:0]   dest;

    // Compare every valid entry against the request key
    always_comb
    begin
        found = '0;
        for (int s = 0; s < DEPTH; s++)
        begin
            match[s] = valid_reg[s] && (key_reg[s] == req.key);
            if (match[s])
            begin
                found = found | handle_reg[s];
            end
        end
    end

    assign hit = |match;

    // Clamp the limit to one through the table depth
    always_comb
    begin
        if (entry_limit == '0)
        begin
            limit_eff = LIMIT_BITS'(1);
        end
        else if (entry_limit > LIMIT_BITS'(DEPTH))
        begin
            limit_eff = LIMIT_BITS'(DEPTH);
        end
        else
        begin
            limit_eff = entry_limit;
        end
    end

    assign full       = LIMIT_BITS'(fill_reg) >= limit_eff;
    assign is_new_add = (req.func == FUNC_ADD) && !hit;
    assign do_add     = step && is_new_add;
    // Newest slot follows the ring of held pairs, also after an eviction
    assign dest       = oldest_reg + fill_reg[SLOT_BITS-1:0];

    // Build the response
    always_comb
    begin
        rsp.hit          = hit;
        rsp.found_handle = found;
        rsp.evicted      = is_new_add && full;
        rsp.evicted_key  = (is_new_add && full) ? key_reg[oldest_reg] : '0;
    end

    // Drop the oldest pair when full, then mark the new slot
    always_comb
    begin
        valid_next = valid_reg;
        if (full)
        begin
            valid_next[oldest_reg] = 1'b0;
        end
        valid_next[dest] = 1'b1;
    end

    // Advance ring pointers and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            fill_reg   <= '0;
            oldest_reg <= '0;
        end
        else if (do_add)
        begin
            if (full)
            begin
                oldest_reg <= oldest_reg + SLOT_BITS'(1);
            end
            else
            begin
                fill_reg <= fill_reg + COUNT_BITS'(1);
            end
            valid_reg <= valid_next;
        end
    end

    // Store the new pair
    always_ff @(posedge clk)
    begin
        if (do_add)
        begin
            key_reg[dest]    <= req.key;
            handle_reg[dest] <= req.handle;
        end
    end

endmodule

// File: hw/rtl/fifo_replacement_lookup_cache_top.sv
// Fully associative key-to-handle table of 64 entries with oldest-first
// replacement. Each request (add or lookup) is captured in an input
// register, compared against all entries in parallel while it is held
// there, and its response lands in an output register once that register
// is free. While responses are taken, a new request can be accepted every
// cycle; the combinational parallel key compare sets that rate. An add of
// a key already present only reports the stored handle. The entry_limit
// register (offset 0, reset 64, clamped to 1..64) caps how many pairs are
// held; write it only while the block is idle.
module fifo_replacement_lookup_cache_top
    import frlc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  frlc_req_t            req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output frlc_rsp_t            rsp,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    logic                  in_vld_reg;
    frlc_req_t             in_req_reg;
    logic                  out_vld_reg;
    frlc_rsp_t             out_rsp_reg;
    logic                  advance;
    frlc_rsp_t             store_rsp;
    logic [LIMIT_BITS-1:0] entry_limit;

    frlc_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .entry_limit (entry_limit)
    );

    frlc_store u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .req         (in_req_reg),
        .entry_limit (entry_limit),
        .rsp         (store_rsp)
    );

    // Move the held request on when the response slot is free
    assign advance   = in_vld_reg && (!out_vld_reg || rsp_ready);
    assign req_ready = !in_vld_reg || advance;

    // Hold the input request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            in_vld_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            in_req_reg <= req;
        end
    end

    // Hold the response until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_rsp_reg <= store_rsp;
        end
    end

    assign rsp_valid = out_vld_reg;
    assign rsp       = out_rsp_reg;

endmodule
